/* hw/rtl/bsck_pkg.sv */
// Shared types, codes and sizes for the keyed byte stream cipher.
`default_nettype none

package bsck_pkg;

    // Setup lengths and mix length
    localparam int KEY_LEN     = 64;
    localparam int NONCE_LEN   = 16;
    localparam int MIX_ROUNDS  = 256;

    // State memory geometry
    localparam int STATE_BYTES = 64;
    localparam int ADDR_W      = $clog2(STATE_BYTES);

    // Setup counters are at least as wide as a state address
    localparam int KEY_CNT_W   = ($clog2(KEY_LEN) > ADDR_W) ? $clog2(KEY_LEN) : ADDR_W;
    localparam int NONCE_CNT_W = ($clog2(NONCE_LEN) > ADDR_W) ? $clog2(NONCE_LEN) : ADDR_W;
    localparam int ROUND_W     = 8;

    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [7:0]             byte_t;
    typedef logic [KEY_CNT_W-1:0]   key_cnt_t;
    typedef logic [NONCE_CNT_W-1:0] nonce_cnt_t;
    typedef logic [ROUND_W-1:0]     round_t;

    localparam key_cnt_t   KEY_LAST   = KEY_CNT_W'(KEY_LEN - 1);
    localparam nonce_cnt_t NONCE_LAST = NONCE_CNT_W'(NONCE_LEN - 1);
    localparam round_t     ROUND_LAST = ROUND_W'(MIX_ROUNDS - 1);

    // Request commands
    localparam logic [1:0] CMD_KEY     = 2'd0;
    localparam logic [1:0] CMD_NONCE   = 2'd1;
    localparam logic [1:0] CMD_DATA    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Setup phases
    localparam logic [1:0] PHASE_KEY   = 2'd0;
    localparam logic [1:0] PHASE_NONCE = 2'd1;
    localparam logic [1:0] PHASE_READY = 2'd2;

    // Result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_ORDER     = 2'd2;

    // Control from the sequencer to the state memory
    typedef struct packed {
        logic  clear;
        logic  we;
        addr_t waddr;
        byte_t wdata;
        addr_t raddr_a;
        addr_t raddr_b;
    } ram_req_t;

endpackage

`default_nettype wire

/* hw/rtl/bsck_state_ram.sv */
// 64-byte cipher state memory: one write port, two registered read ports.
`default_nettype none

module bsck_state_ram
    import bsck_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ram_req_t req,
    output logic [7:0]    rdata_a,
    output logic [7:0]    rdata_b
);

    byte_t                   state_mem [STATE_BYTES];
    logic [STATE_BYTES-1:0]  valid_reg;
    byte_t                   rdata_a_reg;
    byte_t                   rdata_b_reg;

    // Array write
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            state_mem[req.waddr] <= req.wdata;
        end
    end

    // Entry valid bits; an entry never written since clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    // Registered reads, write-first on an address match
    always_ff @(posedge clk)
    begin
        if (req.we && (req.waddr == req.raddr_a))
        begin
            rdata_a_reg <= req.wdata;
        end
        else
        begin
            rdata_a_reg <= valid_reg[req.raddr_a] ? state_mem[req.raddr_a] : 8'h00;
        end

        if (req.we && (req.waddr == req.raddr_b))
        begin
            rdata_b_reg <= req.wdata;
        end
        else
        begin
            rdata_b_reg <= valid_reg[req.raddr_b] ? state_mem[req.raddr_b] : 8'h00;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

/* hw/rtl/byte_stream_cipher_keyed_nonce.sv */
// Top level of the keyed byte stream cipher: request sequencer around the state memory.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   input   | in        | in_valid / in_ready    | command, in_byte, last_item
//   output  | out       | out_valid / out_ready  | out_byte, last_out, status
//
// A key, nonce or data request reads the state memory, then modifies it and
// writes it back. Error and restart requests complete in the idle state.
// The last key byte and the last nonce byte each start MIX_ROUNDS mix rounds,
// one mix round per cycle through the single read-modify-write path of the memory.
// Reset and restart clear the state at once through per-entry valid bits.
// A request is taken only while the sequencer is idle and the output register
// is empty or being emptied in the same cycle.
`default_nettype none

module byte_stream_cipher_keyed_nonce
    import bsck_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] in_byte,
    input  wire logic       last_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last_out,
    output logic [1:0]      status
);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_MIX  = 2'd2;

    logic [1:0] state_reg,  state_next;
    logic [1:0] cmd_reg,    cmd_next;
    byte_t      byte_reg,   byte_next;
    logic       last_reg,   last_next;
    byte_t      acc_reg,    acc_next;
    addr_t      pos_reg,    pos_next;
    byte_t      bcnt_reg,   bcnt_next;
    key_cnt_t   kcnt_reg,   kcnt_next;
    nonce_cnt_t ncnt_reg,   ncnt_next;
    logic [1:0] phase_reg,  phase_next;
    round_t     round_reg,  round_next;
    logic       out_valid_reg, out_valid_next;
    byte_t      out_byte_reg,  out_byte_next;
    logic       last_out_reg,  last_out_next;
    logic [1:0] status_reg,    status_next;

    ram_req_t   ram_req;
    byte_t      rdata_a;
    byte_t      rdata_b;
    logic       in_fire;

    // Datapath values for the write-back cycle
    addr_t      absorb_idx;
    byte_t      absorb_val;
    byte_t      data_val;
    byte_t      data_acc;
    byte_t      mix_val;
    byte_t      mix_acc;

    bsck_state_ram u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    assign absorb_idx = (cmd_reg == CMD_KEY) ? kcnt_reg[ADDR_W-1:0] : ncnt_reg[ADDR_W-1:0];
    assign absorb_val = rdata_a + byte_reg;
    assign data_val   = rdata_a + rdata_b + acc_reg;
    assign data_acc   = acc_reg + data_val + bcnt_reg;
    assign mix_val    = rdata_a + acc_reg;
    assign mix_acc    = acc_reg + mix_val + round_reg;

    // Sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        bcnt_next      = bcnt_reg;
        kcnt_next      = kcnt_reg;
        ncnt_next      = ncnt_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_out_next  = last_out_reg;
        status_next    = status_reg;
        ram_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = command;
                    byte_next = in_byte;
                    last_next = last_item;
                    unique case (command)
                        CMD_RESTART:
                        begin
                            ram_req.clear = 1'b1;
                            acc_next      = '0;
                            pos_next      = '0;
                            bcnt_next     = '0;
                            kcnt_next     = '0;
                            ncnt_next     = '0;
                            phase_next    = PHASE_KEY;
                        end
                        CMD_KEY:
                        begin
                            if (phase_reg != PHASE_KEY)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = '0;
                                last_out_next  = 1'b0;
                                status_next    = ST_ORDER;
                            end
                            else
                            begin
                                ram_req.raddr_a = kcnt_reg[ADDR_W-1:0];
                                state_next      = S_RMW;
                            end
                        end
                        CMD_NONCE:
                        begin
                            if (phase_reg != PHASE_NONCE)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = '0;
                                last_out_next  = 1'b0;
                                status_next    = ST_ORDER;
                            end
                            else
                            begin
                                ram_req.raddr_a = ncnt_reg[ADDR_W-1:0];
                                state_next      = S_RMW;
                            end
                        end
                        default:
                        begin
                            // data request
                            if (phase_reg != PHASE_READY)
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = '0;
                                last_out_next  = last_item;
                                status_next    = ST_NOT_READY;
                            end
                            else
                            begin
                                ram_req.raddr_a = pos_reg;
                                ram_req.raddr_b = pos_reg + 1'b1;
                                state_next      = S_RMW;
                            end
                        end
                    endcase
                end
            end

            S_RMW:
            begin
                if (cmd_reg == CMD_DATA)
                begin
                    // keystream byte and result
                    ram_req.we     = 1'b1;
                    ram_req.waddr  = pos_reg;
                    ram_req.wdata  = data_val;
                    acc_next       = data_acc;
                    out_valid_next = 1'b1;
                    out_byte_next  = byte_reg ^ (data_acc ^ data_val);
                    last_out_next  = last_reg;
                    status_next    = ST_OK;
                    pos_next       = pos_reg + 1'b1;
                    bcnt_next      = bcnt_reg + 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // absorb a key or nonce byte
                    ram_req.we    = 1'b1;
                    ram_req.waddr = absorb_idx;
                    ram_req.wdata = absorb_val;
                    acc_next      = acc_reg + absorb_val;
                    state_next    = S_IDLE;
                    if (cmd_reg == CMD_KEY)
                    begin
                        kcnt_next = kcnt_reg + 1'b1;
                        if (kcnt_reg == KEY_LAST)
                        begin
                            phase_next = PHASE_NONCE;
                            state_next = S_MIX;
                        end
                    end
                    else
                    begin
                        ncnt_next = ncnt_reg + 1'b1;
                        if (ncnt_reg == NONCE_LAST)
                        begin
                            phase_next = PHASE_READY;
                            state_next = S_MIX;
                        end
                    end
                    // first mix round reads entry zero, forwarded if just written
                    ram_req.raddr_a = '0;
                    round_next      = '0;
                end
            end

            S_MIX:
            begin
                // one mix round per cycle; next round's read overlaps this write
                ram_req.we      = 1'b1;
                ram_req.waddr   = round_reg[ADDR_W-1:0];
                ram_req.wdata   = mix_val;
                acc_next        = mix_acc;
                ram_req.raddr_a = round_reg[ADDR_W-1:0] + 1'b1;
                round_next      = round_reg + 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and cipher state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            pos_reg       <= '0;
            bcnt_reg      <= '0;
            kcnt_reg      <= '0;
            ncnt_reg      <= '0;
            phase_reg     <= PHASE_KEY;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            bcnt_reg      <= bcnt_next;
            kcnt_reg      <= kcnt_next;
            ncnt_reg      <= ncnt_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        last_out_reg <= last_out_next;
        status_reg   <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_out  = last_out_reg;
    assign status    = status_reg;

    // A ready data request yields its result after the write-back cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (command == CMD_DATA) && (phase_reg == PHASE_READY))
            |=> (state_reg == S_RMW) ##1 out_valid_reg)
        else $error("data request did not produce a result");

    // Setup stays complete until a restart request
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PHASE_READY) && !(in_fire && (command == CMD_RESTART)))
            |=> (phase_reg == PHASE_READY))
        else $error("setup phase left ready without restart");

    // A mix only runs after the key stage has completed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) |-> (phase_reg != PHASE_KEY))
        else $error("mix running while awaiting key bytes");

    // The state memory is never written while the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg != S_IDLE) && !ram_req.clear)
        else $error("state memory write outside a busy cycle");

endmodule

`default_nettype wire
